@@ src/heading_error_to_target_macros.svh @@
// Assertion helpers for the heading error pipeline.
`ifndef HEADING_ERROR_TO_TARGET_MACROS_SVH
`define HEADING_ERROR_TO_TARGET_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted.
`define HET_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define HET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HET_ASSERT(lbl, clk, rst_n, prop, msg)
`define HET_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ src/het_pkg.sv @@
package het_pkg;

	localparam int COORD_BITS_DEF      = 12;
	localparam int ANGLE_FRAC_BITS_DEF = 7;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int HEADING_BITS = 16;
	localparam int GUARD_BITS   = 24;
	localparam int TABLE_LEN    = 24;
	// signed picodegree angle accumulator, |z| < 190 deg
	localparam int ZW           = 49;

	localparam logic [63:0] PICO_PER_DEG = 64'd1000000000000;

	// atan(2^-i) in picodegrees, rounded to nearest
	localparam logic signed [63:0] ATAN_PICO [TABLE_LEN] = '{
		64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926,
		64'sd7125016348902,  64'sd3576334374997,  64'sd1789910608246,
		64'sd895173710211,   64'sd447614170861,   64'sd223810500369,
		64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
		64'sd13988227142,    64'sd6994113675,     64'sd3497056851,
		64'sd1748528427,     64'sd874264214,      64'sd437132107,
		64'sd218566053,      64'sd109283027,      64'sd54641513,
		64'sd27320757,       64'sd13660378,       64'sd6830189
	};

endpackage

@@ src/heading_error_to_target.sv @@
// The result is presented on heading_error with done high for one cycle
// per accepted transaction.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Depth is set by the CORDIC stages plus a three-stage reciprocal divide by one degree.
// Reset (arst_n low, asynchronous) clears all valid bits; no transaction is in flight after it.
`include "heading_error_to_target_macros.svh"

module heading_error_to_target
	import het_pkg::*;
#(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [COORD_BITS-1:0]          robot_x,
	input  logic [COORD_BITS-1:0]          robot_y,
	input  logic signed [HEADING_BITS-1:0] robot_heading,
	input  logic [COORD_BITS-1:0]          target_x,
	input  logic [COORD_BITS-1:0]          target_y,
	output logic                           done,
	output logic signed [HEADING_BITS-1:0] heading_error
);

	localparam int NS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int DW     = COORD_BITS + 1;
	localparam int XW     = COORD_BITS + GUARD_BITS + 3;
	localparam int FULL   = 360 * (2 ** ANGLE_FRAC_BITS);
	localparam int HALF   = FULL / 2;
	localparam int K      = (32768 + FULL - 1) / FULL;
	localparam int RSTEPS = $clog2(2 * K + 1);
	localparam int HRW    = $clog2(2 * FULL * (K + 1) + 32768) + 1;
	localparam int RW     = $clog2(FULL);
	localparam int QB     = 9 + ANGLE_FRAC_BITS;
	localparam int NW     = 50 + ANGLE_FRAC_BITS;
	localparam int EW     = QB + 2;
	localparam int SC     = 2 + NS;
	localparam int SB     = SC + 1;
	localparam int SN     = SB + 1;
	localparam int SE     = SN + 1;
	localparam int SR     = SE + 1;
	localparam int SD     = SR + 1;
	localparam int SO     = SD + 1;

	// 2^DIV_SH <= one degree / 4, so the estimate is low by at most one
	localparam int DIV_SH  = 37;
	localparam int TW      = NW - DIV_SH;
	localparam int DIV_P   = TW + 2;
	localparam int LW      = 42;
	localparam int PICO_TZ = 12;

	localparam logic [127:0]  RECIP_W  = (128'd1 << (DIV_P + DIV_SH)) / 128'(PICO_PER_DEG);
	localparam logic [TW-1:0] RECIP    = RECIP_W[TW-1:0];
	localparam logic [27:0]   PICO_ODD = 28'(PICO_PER_DEG >> PICO_TZ);
	localparam logic [LW-1:0] PICO_L   = LW'(PICO_PER_DEG);

	localparam logic signed [ZW-1:0] Z90       = ZW'(90 * PICO_PER_DEG);
	localparam logic signed [ZW:0]   FULL_PICO = (ZW + 1)'(360 * PICO_PER_DEG);
	localparam logic signed [EW-1:0] FULL_E    = EW'(FULL);
	localparam logic signed [EW-1:0] HALF_E    = EW'(HALF);

	logic [SO:1] v_s;

	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic [HRW-1:0]        hp_s [1:SD];
	logic                  zf_s [1:SD];
	logic signed [XW-1:0]  x_s  [2:SC];
	logic signed [XW-1:0]  y_s  [2:SC];
	logic signed [ZW-1:0]  z_s  [2:SC];
	logic [ZW-1:0]         b_s;
	logic [NW-1:0]         n_s;
	logic [QB-1:0]         qe_s [SE:SR];
	logic [LW-1:0]         nl_s [SE:SR];
	logic [LW-1:0]         pr_s;
	logic [QB-1:0]         q_s;
	logic signed [HEADING_BITS-1:0] err_q;

	logic signed [XW-1:0] ex, ey;
	logic signed [ZW:0]   bsum;
	logic [2*TW-1:0]      tm;
	logic [QB+27:0]       pm;
	logic [LW-1:0]        rd;
	logic [QB-1:0]        qa;
	logic signed [EW-1:0] dd, dw;

	assign busy          = 1'b0;
	assign done          = v_s[SO];
	assign heading_error = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[SO-1:1], start && !busy};
		end
	end

	// stage 1: differences, heading offset to non-negative
	always_ff @(posedge clk) begin
		dx_s1   <= $signed({1'b0, target_x}) - $signed({1'b0, robot_x});
		dy_s1   <= $signed({1'b0, target_y}) - $signed({1'b0, robot_y});
		zf_s[1] <= (target_x == robot_x) && (target_y == robot_y);
		hp_s[1] <= HRW'(robot_heading) + HRW'(K * FULL);
	end

	// stage 2: guard scaling and quadrant pre-rotation
	always_comb begin
		ex = XW'(dx_s1) <<< GUARD_BITS;
		ey = XW'(dy_s1) <<< GUARD_BITS;
	end

	always_ff @(posedge clk) begin
		zf_s[2] <= zf_s[1];
		hp_s[2] <= hp_s[1];
		if (dx_s1[DW-1]) begin
			if (!dy_s1[DW-1]) begin
				x_s[2] <= ey;
				y_s[2] <= -ex;
				z_s[2] <= Z90;
			end else begin
				x_s[2] <= -ey;
				y_s[2] <= ex;
				z_s[2] <= -Z90;
			end
		end else begin
			x_s[2] <= ex;
			y_s[2] <= ey;
			z_s[2] <= '0;
		end
	end

	// vectoring CORDIC; heading modulo runs alongside the first stages
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_PICO[i]);

		always_ff @(posedge clk) begin
			zf_s[i+3] <= zf_s[i+2];
			if (!y_s[i+2][XW-1]) begin
				x_s[i+3] <= x_s[i+2] + (y_s[i+2] >>> i);
				y_s[i+3] <= y_s[i+2] - (x_s[i+2] >>> i);
				z_s[i+3] <= z_s[i+2] + ANG;
			end else begin
				x_s[i+3] <= x_s[i+2] - (y_s[i+2] >>> i);
				y_s[i+3] <= y_s[i+2] + (x_s[i+2] >>> i);
				z_s[i+3] <= z_s[i+2] - ANG;
			end
		end

		if (i < RSTEPS) begin : g_red
			localparam logic [HRW-1:0] SUB = HRW'(FULL) << (RSTEPS - 1 - i);

			always_ff @(posedge clk) begin
				hp_s[i+3] <= (hp_s[i+2] >= SUB) ? hp_s[i+2] - SUB : hp_s[i+2];
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				hp_s[i+3] <= hp_s[i+2];
			end
		end
	end

	// bearing to [0, 360)
	assign bsum = (ZW + 1)'(z_s[SC]) + (z_s[SC][ZW-1] ? FULL_PICO : '0);

	always_ff @(posedge clk) begin
		b_s      <= bsum[ZW-1:0];
		zf_s[SB] <= zf_s[SC];
		hp_s[SB] <= hp_s[SC];
	end

	// scale to output units, add rounding half
	always_ff @(posedge clk) begin
		n_s      <= (NW'(b_s) << ANGLE_FRAC_BITS) + NW'(PICO_PER_DEG / 2);
		zf_s[SN] <= zf_s[SB];
		hp_s[SN] <= hp_s[SB];
	end

	// divide by one degree in picodegrees: reciprocal estimate, then one correction
	assign tm = n_s[NW-1:DIV_SH] * RECIP;

	always_ff @(posedge clk) begin
		qe_s[SE] <= tm[DIV_P +: QB];
		nl_s[SE] <= n_s[LW-1:0];
		zf_s[SE] <= zf_s[SN];
		hp_s[SE] <= hp_s[SN];
	end

	// one degree is PICO_ODD * 2^PICO_TZ
	assign pm = qe_s[SE] * PICO_ODD;

	always_ff @(posedge clk) begin
		pr_s     <= {pm[LW-PICO_TZ-1:0], {PICO_TZ{1'b0}}};
		qe_s[SR] <= qe_s[SE];
		nl_s[SR] <= nl_s[SE];
		zf_s[SR] <= zf_s[SE];
		hp_s[SR] <= hp_s[SE];
	end

	assign rd = nl_s[SR] - pr_s;

	always_ff @(posedge clk) begin
		q_s      <= qe_s[SR] + QB'(rd >= PICO_L);
		zf_s[SD] <= zf_s[SR];
		hp_s[SD] <= hp_s[SR];
	end

	// bearing minus heading, wrapped once
	always_comb begin
		qa = (zf_s[SD] || (q_s == QB'(FULL))) ? '0 : q_s;
		dd = $signed(EW'(qa)) - $signed(EW'(hp_s[SD][RW-1:0]));
		if (dd > HALF_E) begin
			dw = dd - FULL_E;
		end else if (dd < -HALF_E) begin
			dw = dd + FULL_E;
		end else begin
			dw = dd;
		end
	end

	always_ff @(posedge clk) begin
		err_q <= HEADING_BITS'(dw);
	end

	`HET_ASSERT(a_done_latency, clk, arst_n, start && !busy |-> ##SO done, "transaction lost")
	`HET_ASSERT(a_done_origin, clk, arst_n, done |-> $past(start && !busy, SO), "spurious done")
	`HET_ASSERT(a_heading_reduced, clk, arst_n, v_s[SB] |-> hp_s[SB] < HRW'(FULL), "heading not reduced")
	`HET_ASSERT(a_div_estimate, clk, arst_n, v_s[SR] |-> rd < (PICO_L << 1), "divide estimate too low")
	`HET_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !done, "done during reset")

endmodule

@@ tb/tb_heading_error_to_target.sv @@
`timescale 1ns / 100ps

module tb_heading_error_to_target;
	import het_pkg::*;

	localparam int COORD_W    = COORD_BITS_DEF;
	localparam int FRAC_W     = ANGLE_FRAC_BITS_DEF;
	localparam int STAGES     = CORDIC_STAGES_DEF;
	localparam int LATENCY    = STAGES + 7;
	localparam int QUIET_MAX  = 2000;
	localparam int PHASE_LEN  = 435;

	typedef struct {
		logic [COORD_W-1:0]             robot_x;
		logic [COORD_W-1:0]             robot_y;
		logic signed [HEADING_BITS-1:0] robot_heading;
		logic [COORD_W-1:0]             target_x;
		logic [COORD_W-1:0]             target_y;
	} nav_query_t;

	class heading_scoreboard;
		localparam longint PICO_DEG  = 64'sd1000000000000;
		localparam longint SCALE     = 64'sd1 << FRAC_W;
		localparam longint FULL_TURN = 360 * SCALE;
		localparam longint HALF_TURN = 180 * SCALE;
		localparam longint ARCTAN_PICO [24] = '{
			64'sd45000000000000, 64'sd26565051177078, 64'sd14036243467926,
			64'sd7125016348902,  64'sd3576334374997,  64'sd1789910608246,
			64'sd895173710211,   64'sd447614170861,   64'sd223810500369,
			64'sd111905677066,   64'sd55952891894,    64'sd27976452617,
			64'sd13988227142,    64'sd6994113675,     64'sd3497056851,
			64'sd1748528427,     64'sd874264214,      64'sd437132107,
			64'sd218566053,      64'sd109283027,      64'sd54641513,
			64'sd27320757,       64'sd13660378,       64'sd6830189
		};

		logic signed [HEADING_BITS-1:0] expected_errors[$];
		int errors;

		function longint bearing_pico(longint dx, longint dy);
			longint x, y, z, t, xs, ys;
			x = dx * (64'sd1 << 24);
			y = dy * (64'sd1 << 24);
			z = 0;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = 90 * PICO_DEG;
				end else begin
					t = x; x = -y; y = t; z = -90 * PICO_DEG;
				end
			end
			for (int i = 0; i < STAGES && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + ARCTAN_PICO[i];
				end else begin
					x = x - ys; y = y + xs; z = z - ARCTAN_PICO[i];
				end
			end
			return z;
		endfunction

		function logic signed [HEADING_BITS-1:0] predict_heading_error(nav_query_t q);
			longint dx, dy, b, bearing_q, hdg, diff;
			dx = longint'(q.target_x) - longint'(q.robot_x);
			dy = longint'(q.target_y) - longint'(q.robot_y);
			bearing_q = 0;
			if (dx != 0 || dy != 0) begin
				b = bearing_pico(dx, dy);
				if (b < 0)
					b = b + 360 * PICO_DEG;
				if (b < 0)
					b = 0;
				bearing_q = (b * SCALE + PICO_DEG / 2) / PICO_DEG;
				if (bearing_q >= FULL_TURN)
					bearing_q = bearing_q - FULL_TURN;
			end
			hdg = longint'(q.robot_heading) % FULL_TURN;
			if (hdg < 0)
				hdg = hdg + FULL_TURN;
			diff = bearing_q - hdg;
			if (diff > HALF_TURN)
				diff = diff - FULL_TURN;
			if (diff < -HALF_TURN)
				diff = diff + FULL_TURN;
			return diff[HEADING_BITS-1:0];
		endfunction

		function void note_query(nav_query_t q);
			expected_errors.push_back(predict_heading_error(q));
		endfunction

		function void check_result(logic signed [HEADING_BITS-1:0] got);
			logic signed [HEADING_BITS-1:0] want;
			if (expected_errors.size() == 0) begin
				$error("heading_error: no transaction pending, got %0d", got);
				errors++;
				return;
			end
			want = expected_errors.pop_front();
			if (got !== want) begin
				$error("heading_error: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function void check_drained();
			if (expected_errors.size() != 0) begin
				$error("heading_error: %0d results never arrived", expected_errors.size());
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [COORD_W-1:0]             robot_x;
	logic [COORD_W-1:0]             robot_y;
	logic signed [HEADING_BITS-1:0] robot_heading;
	logic [COORD_W-1:0]             target_x;
	logic [COORD_W-1:0]             target_y;
	logic                           done;
	logic signed [HEADING_BITS-1:0] heading_error;

	heading_scoreboard sb = new;
	int quiet_cycles = 0;

	heading_error_to_target #(
		.COORD_BITS(COORD_W),
		.ANGLE_FRAC_BITS(FRAC_W),
		.CORDIC_STAGES(STAGES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.robot_x(robot_x),
		.robot_y(robot_y),
		.robot_heading(robot_heading),
		.target_x(target_x),
		.target_y(target_y),
		.done(done),
		.heading_error(heading_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(heading_error);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic nav_query_t make_query(int rx, int ry, int hdg, int tx, int ty);
		nav_query_t q;
		q.robot_x       = rx[COORD_W-1:0];
		q.robot_y       = ry[COORD_W-1:0];
		q.robot_heading = hdg[HEADING_BITS-1:0];
		q.target_x      = tx[COORD_W-1:0];
		q.target_y      = ty[COORD_W-1:0];
		return q;
	endfunction

	function automatic nav_query_t random_query();
		nav_query_t q;
		int mode;
		mode = $urandom_range(99);
		q.robot_x  = COORD_W'($urandom);
		q.robot_y  = COORD_W'($urandom);
		q.target_x = COORD_W'($urandom);
		q.target_y = COORD_W'($urandom);
		if ($urandom_range(1))
			q.robot_heading = HEADING_BITS'($urandom);
		else
			q.robot_heading = HEADING_BITS'($urandom_range(46080) - 23040);
		if (mode >= 60 && mode < 80) begin
			// near neighbors: small offsets of either sign
			q.target_x = q.robot_x ^ COORD_W'($urandom_range(7));
			q.target_y = q.robot_y ^ COORD_W'($urandom_range(7));
		end else if (mode >= 80 && mode < 88) begin
			q.target_x = q.robot_x;
		end else if (mode >= 88 && mode < 96) begin
			q.target_y = q.robot_y;
		end else if (mode >= 96) begin
			q.target_x = q.robot_x;
			q.target_y = q.robot_y;
		end
		return q;
	endfunction

	task automatic send_query(nav_query_t q, int idle_pct);
		robot_x       <= q.robot_x;
		robot_y       <= q.robot_y;
		robot_heading <= q.robot_heading;
		target_x      <= q.target_x;
		target_y      <= q.target_y;
		start         <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_query(q);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_errors.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int idle_pcts[4];
		idle_pcts = '{0, 57, 0, 7};
		arst_n        = 1'b0;
		start         = 1'b0;
		robot_x       = '0;
		robot_y       = '0;
		robot_heading = '0;
		target_x      = '0;
		target_y      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coincident points, heading extremes
		send_query(make_query(0, 0, 0, 0, 0), 0);
		send_query(make_query(4095, 4095, -32768, 4095, 4095), 0);
		send_query(make_query(1234, 777, 32767, 1234, 777), 0);
		// axes and quadrants, including the pre-rotation cases
		send_query(make_query(0, 0, 0, 4095, 0), 0);
		send_query(make_query(4095, 0, 23040, 0, 0), 0);
		send_query(make_query(0, 0, -23040, 0, 4095), 0);
		send_query(make_query(0, 4095, 0, 0, 0), 0);
		send_query(make_query(4095, 4095, 0, 0, 0), 0);
		send_query(make_query(0, 4095, -32768, 4095, 0), 0);
		send_query(make_query(4095, 0, 32767, 0, 4095), 0);
		send_query(make_query(100, 100, 0, 101, 99), 0);
		send_query(make_query(100, 100, 0, 99, 100), 0);
		send_query(make_query(4095, 4095, 1, 4094, 0), 0);
		send_query(make_query(0, 1, 0, 4095, 0), 0);
		send_query(make_query(4095, 1, 0, 0, 0), 0);
		send_query(make_query(4095, 0, -1, 0, 1), 0);
		// wrap of the difference at +-180 and out-of-range headings
		send_query(make_query(0, 0, 23040, 10, 0), 0);
		send_query(make_query(0, 0, -23040, 10, 0), 0);
		send_query(make_query(0, 0, 23041, 10, 0), 0);
		send_query(make_query(0, 0, -23041, 10, 0), 0);
		send_query(make_query(0, 0, -1, 10, 0), 0);
		send_query(make_query(10, 0, -32768, 0, 0), 0);
		send_query(make_query(10, 0, 32767, 0, 0), 0);
		drain();

		foreach (idle_pcts[p]) begin
			for (int n = 0; n < PHASE_LEN; n++)
				send_query(random_query(), idle_pcts[p]);
			drain();
		end

		repeat (LATENCY + 8) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
